>>> src/dppc_pkg.sv
// dppc_pkg: constants, codes and shared types of the delimited packet parser
// used by dppc_core, the top level and the port checker; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dppc_pkg;

    localparam int FIELD_BYTES = 32;
    localparam int MAX_FIELDS  = 8;

    localparam int POS_W   = $clog2(FIELD_BYTES + 1);
    localparam int FIELD_W = $clog2(MAX_FIELDS + 1);

    localparam logic [7:0] CH_START = 8'h3C;
    localparam logic [7:0] CH_END   = 8'h3E;
    localparam logic [7:0] CH_SEP   = 8'h7C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [3:0] CMD_DIGITS_MAX = 4'd9;
    localparam logic [1:0] SUM_DIGITS_MAX = 2'd3;

    typedef enum logic [2:0] {
        PH_WAIT      = 3'd0,
        PH_CMD_FIRST = 3'd1,
        PH_CMD_MORE  = 3'd2,
        PH_ARGS      = 3'd3,
        PH_SUM_FIRST = 3'd4,
        PH_SUM_MORE  = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_CMD_START = 3'd1,
        ST_CMD_CHAR  = 3'd2,
        ST_UNKNOWN   = 3'd3,
        ST_ARG       = 3'd4,
        ST_SUM_START = 3'd5,
        ST_SUM_CHAR  = 3'd6,
        ST_MISMATCH  = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        REG_CMD_CODE_A  = 3'd0,
        REG_CMD_CODE_B  = 3'd1,
        REG_CMD_CODE_C  = 3'd2,
        REG_CMD_CODE_D  = 3'd3,
        REG_ARG_COUNT_A = 3'd4,
        REG_ARG_COUNT_B = 3'd5,
        REG_ARG_COUNT_C = 3'd6,
        REG_ARG_COUNT_D = 3'd7
    } t_reg_idx;

    localparam logic RK_BYTE    = 1'b0;
    localparam logic RK_VERDICT = 1'b1;

    typedef struct packed {
        logic [7:0] code_a;
        logic [7:0] code_b;
        logic [7:0] code_c;
        logic [7:0] code_d;
        logic [3:0] count_a;
        logic [3:0] count_b;
        logic [3:0] count_c;
        logic [3:0] count_d;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [2:0] index;
        logic [5:0] pos;
        logic [7:0] data;
        t_status    status;
        logic [7:0] command;
    } t_result;

endpackage

`default_nettype wire

>>> src/delimited_packet_parser_checksum_unit.sv
// delimited packet parser top level: input word register, configuration
// registers, dppc_core and result register; depends on dppc_pkg and dppc_core
// an accepted input word passes the input register, dppc_core and the result register
// throughput: one word per cycle while the output is not stalled
// stall on the output holds the result register and, while it holds a word, the input register
// reset (synchronous, active low) empties both registers, returns the parser
// to waiting for a start character and loads the default command table
`timescale 1ns / 1ps
`default_nettype none

module delimited_packet_parser_checksum_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_result_kind,
    output logic [2:0]      o_field_index,
    output logic [5:0]      o_field_pos,
    output logic [7:0]      o_field_byte,
    output logic [2:0]      o_status,
    output logic [7:0]      o_command,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    dppc_pkg::t_cfg    r_cfg;
    dppc_pkg::t_result r_out;
    dppc_pkg::t_result res;
    logic              advance;

    assign advance     = !r_out.valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code_a  <= 8'd1;
            r_cfg.code_b  <= 8'd2;
            r_cfg.code_c  <= 8'd3;
            r_cfg.code_d  <= 8'd4;
            r_cfg.count_a <= 4'd2;
            r_cfg.count_b <= 4'd5;
            r_cfg.count_c <= 4'd0;
            r_cfg.count_d <= 4'd3;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (dppc_pkg::t_reg_idx'(i_cfg_index))
                dppc_pkg::REG_CMD_CODE_A:  r_cfg.code_a  <= i_cfg_data;
                dppc_pkg::REG_CMD_CODE_B:  r_cfg.code_b  <= i_cfg_data;
                dppc_pkg::REG_CMD_CODE_C:  r_cfg.code_c  <= i_cfg_data;
                dppc_pkg::REG_CMD_CODE_D:  r_cfg.code_d  <= i_cfg_data;
                dppc_pkg::REG_ARG_COUNT_A: r_cfg.count_a <= i_cfg_data[3:0];
                dppc_pkg::REG_ARG_COUNT_B: r_cfg.count_b <= i_cfg_data[3:0];
                dppc_pkg::REG_ARG_COUNT_C: r_cfg.count_c <= i_cfg_data[3:0];
                dppc_pkg::REG_ARG_COUNT_D: r_cfg.count_d <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    dppc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (r_in_valid && advance),
        .i_byte  (r_in_byte),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (advance) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out.valid;
    assign o_result_kind = r_out.kind;
    assign o_field_index = r_out.index;
    assign o_field_pos   = r_out.pos;
    assign o_field_byte  = r_out.data;
    assign o_status      = r_out.status;
    assign o_command     = r_out.command;

endmodule

`default_nettype wire

>>> src/dppc_core.sv
// dppc_core: parser state machine, command lookup and running checksum
// one word per step, result produced combinationally; depends on dppc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dppc_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [7:0]        i_byte,
    input  wire dppc_pkg::t_cfg    i_cfg,
    output dppc_pkg::t_result      o_res
);

    dppc_pkg::t_phase                  r_phase, n_phase;
    logic [7:0]                        r_sum, n_sum;
    logic [7:0]                        r_cmd, n_cmd;
    logic [3:0]                        r_cdig, n_cdig;
    logic [dppc_pkg::FIELD_W-1:0]      r_need, n_need;
    logic [dppc_pkg::FIELD_W-1:0]      r_field, n_field;
    logic [dppc_pkg::POS_W-1:0]        r_pos, n_pos;
    logic [7:0]                        r_rsum, n_rsum;
    logic [1:0]                        r_sdig, n_sdig;

    logic                              is_digit;
    logic [7:0]                        digit;
    logic                              hit;
    logic [3:0]                        count;
    logic [dppc_pkg::FIELD_W-1:0]      field_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dppc_pkg::PH_WAIT;
            r_sum   <= '0;
            r_cmd   <= '0;
            r_cdig  <= '0;
            r_need  <= '0;
            r_field <= '0;
            r_pos   <= '0;
            r_rsum  <= '0;
            r_sdig  <= '0;
        end else begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_cmd   <= n_cmd;
            r_cdig  <= n_cdig;
            r_need  <= n_need;
            r_field <= n_field;
            r_pos   <= n_pos;
            r_rsum  <= n_rsum;
            r_sdig  <= n_sdig;
        end
    end

    always_comb begin
        is_digit  = i_byte inside {[dppc_pkg::CH_ZERO:dppc_pkg::CH_NINE]};
        digit     = {4'd0, i_byte[3:0]};
        field_inc = r_field + 1'b1;

        // first matching code wins
        hit   = 1'b1;
        count = '0;
        if (i_cfg.code_a == r_cmd) begin
            count = i_cfg.count_a;
        end else if (i_cfg.code_b == r_cmd) begin
            count = i_cfg.count_b;
        end else if (i_cfg.code_c == r_cmd) begin
            count = i_cfg.count_c;
        end else if (i_cfg.code_d == r_cmd) begin
            count = i_cfg.count_d;
        end else begin
            hit = 1'b0;
        end

        n_phase = r_phase;
        n_sum   = r_sum;
        n_cmd   = r_cmd;
        n_cdig  = r_cdig;
        n_need  = r_need;
        n_field = r_field;
        n_pos   = r_pos;
        n_rsum  = r_rsum;
        n_sdig  = r_sdig;

        o_res         = '0;
        o_res.kind    = dppc_pkg::RK_VERDICT;
        o_res.command = r_cmd;

        if (i_step) begin
            case (r_phase)
                dppc_pkg::PH_WAIT: begin
                    if (i_byte == dppc_pkg::CH_START) begin
                        n_phase = dppc_pkg::PH_CMD_FIRST;
                        n_sum   = '0;
                        n_cmd   = '0;
                        n_cdig  = '0;
                        n_need  = '0;
                        n_field = '0;
                        n_pos   = '0;
                        n_rsum  = '0;
                        n_sdig  = '0;
                    end
                end
                dppc_pkg::PH_CMD_FIRST: begin
                    if (!is_digit) begin
                        o_res.valid  = 1'b1;
                        o_res.status = dppc_pkg::ST_CMD_START;
                        n_phase      = dppc_pkg::PH_WAIT;
                    end else begin
                        n_cmd   = digit;
                        n_cdig  = 4'd1;
                        n_sum   = r_sum + i_byte;
                        n_phase = dppc_pkg::PH_CMD_MORE;
                    end
                end
                dppc_pkg::PH_CMD_MORE: begin
                    if (is_digit && r_cdig < dppc_pkg::CMD_DIGITS_MAX) begin
                        // times ten as two shifts
                        n_cmd  = {r_cmd[4:0], 3'd0} + {r_cmd[6:0], 1'b0} + digit;
                        n_cdig = r_cdig + 4'd1;
                        n_sum  = r_sum + i_byte;
                    end else if (i_byte != dppc_pkg::CH_SEP) begin
                        o_res.valid  = 1'b1;
                        o_res.status = dppc_pkg::ST_CMD_CHAR;
                        n_phase      = dppc_pkg::PH_WAIT;
                    end else if (!hit) begin
                        o_res.valid  = 1'b1;
                        o_res.status = dppc_pkg::ST_UNKNOWN;
                        n_phase      = dppc_pkg::PH_WAIT;
                    end else begin
                        n_sum   = r_sum + i_byte;
                        n_need  = (count > 4'(dppc_pkg::MAX_FIELDS))
                                  ? dppc_pkg::FIELD_W'(dppc_pkg::MAX_FIELDS)
                                  : dppc_pkg::FIELD_W'(count);
                        n_field = '0;
                        n_pos   = '0;
                        n_phase = (count == 4'd0) ? dppc_pkg::PH_SUM_FIRST
                                                  : dppc_pkg::PH_ARGS;
                    end
                end
                dppc_pkg::PH_ARGS: begin
                    if (i_byte == dppc_pkg::CH_START || i_byte == dppc_pkg::CH_END
                        || r_pos >= dppc_pkg::POS_W'(dppc_pkg::FIELD_BYTES)) begin
                        o_res.valid  = 1'b1;
                        o_res.status = dppc_pkg::ST_ARG;
                        n_phase      = dppc_pkg::PH_WAIT;
                    end else if (i_byte == dppc_pkg::CH_SEP) begin
                        n_sum   = r_sum + i_byte;
                        n_field = field_inc;
                        n_pos   = '0;
                        if (field_inc >= r_need) begin
                            n_phase = dppc_pkg::PH_SUM_FIRST;
                        end
                    end else begin
                        n_sum         = r_sum + i_byte;
                        n_pos         = r_pos + 1'b1;
                        o_res.valid   = 1'b1;
                        o_res.kind    = dppc_pkg::RK_BYTE;
                        o_res.index   = 3'(r_field);
                        o_res.pos     = 6'(r_pos);
                        o_res.data    = i_byte;
                        o_res.command = '0;
                    end
                end
                dppc_pkg::PH_SUM_FIRST: begin
                    if (!is_digit) begin
                        o_res.valid  = 1'b1;
                        o_res.status = dppc_pkg::ST_SUM_START;
                        n_phase      = dppc_pkg::PH_WAIT;
                    end else begin
                        n_rsum  = digit;
                        n_sdig  = 2'd1;
                        n_phase = dppc_pkg::PH_SUM_MORE;
                    end
                end
                dppc_pkg::PH_SUM_MORE: begin
                    if (i_byte == dppc_pkg::CH_END) begin
                        o_res.valid  = 1'b1;
                        o_res.status = (r_rsum == r_sum) ? dppc_pkg::ST_OK
                                                         : dppc_pkg::ST_MISMATCH;
                        n_phase      = dppc_pkg::PH_WAIT;
                    end else if (is_digit && r_sdig < dppc_pkg::SUM_DIGITS_MAX) begin
                        // received value kept modulo 256
                        n_rsum = {r_rsum[4:0], 3'd0} + {r_rsum[6:0], 1'b0} + digit;
                        n_sdig = r_sdig + 2'd1;
                    end else begin
                        o_res.valid  = 1'b1;
                        o_res.status = dppc_pkg::ST_SUM_CHAR;
                        n_phase      = dppc_pkg::PH_WAIT;
                    end
                end
                default: begin
                    n_phase = dppc_pkg::PH_WAIT;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/dppc_checker.sv
// dppc_checker: port-level assertions for the delimited packet parser
// bound to delimited_packet_parser_checksum_unit; depends on dppc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dppc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic       o_result_kind,
    input wire logic [2:0] o_field_index,
    input wire logic [5:0] o_field_pos,
    input wire logic [7:0] o_field_byte,
    input wire logic [2:0] o_status,
    input wire logic [7:0] o_command
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled result dropped");

    a_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == dppc_pkg::RK_BYTE |->
            o_status == 3'd0 && o_command == 8'd0
            && o_field_byte != dppc_pkg::CH_START && o_field_byte != dppc_pkg::CH_END)
        else $error("bad stored byte word");

    a_verdict_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == dppc_pkg::RK_VERDICT |->
            o_field_index == 3'd0 && o_field_pos == 6'd0 && o_field_byte == 8'd0)
        else $error("verdict carries field data");

    a_cmd_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == dppc_pkg::RK_VERDICT
            && o_status == dppc_pkg::ST_CMD_START |-> o_command == 8'd0)
        else $error("command start verdict with nonzero command");

endmodule

bind delimited_packet_parser_checksum_unit dppc_checker u_dppc_checker (.*);

`default_nettype wire

>>> tb/tb.sv
// tb: self-checking testbench for delimited_packet_parser_checksum_unit
// a frame generator and a parser predictor check every output word field by field
// depends on dppc_pkg and the parser top level
`timescale 1ns / 1ps

module tb;
    import dppc_pkg::*;

    localparam int LIMIT     = 300000;
    localparam int CALM_FROM = 1100;
    localparam int CALM_TO   = 1500;
    localparam int HOLD_AT   = 500;
    localparam int HOLD_LEN  = 300;
    localparam int PHASE_LEN = 285;

    typedef struct packed {
        logic       kind;
        logic [2:0] index;
        logic [5:0] pos;
        logic [7:0] data;
        t_status    status;
        logic [7:0] command;
    } t_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [2:0] i_cfg_index = 3'd0;
    logic [7:0] i_cfg_data = 8'h00;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_result_kind;
    logic [2:0] o_field_index;
    logic [5:0] o_field_pos;
    logic [7:0] o_field_byte;
    logic [2:0] o_status;
    logic [7:0] o_command;
    logic       o_cfg_ready;

    delimited_packet_parser_checksum_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_result_kind(o_result_kind),
        .o_field_index(o_field_index),
        .o_field_pos  (o_field_pos),
        .o_field_byte (o_field_byte),
        .o_status     (o_status),
        .o_command    (o_command),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    logic [7:0] rx_stream[$];
    t_word      pending_results[$];
    int         cyc = 0;
    int         mismatches = 0;
    int         bytes_taken = 0;
    int         frame_bytes = 0;
    bit         in_taken = 1'b0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;

    // parser image
    logic [7:0] code_tab[4];
    logic [3:0] count_tab[4];
    t_phase     ph;
    logic [7:0] sum_acc;
    logic [7:0] cmd_val;
    logic [3:0] cmd_len;
    logic [3:0] fields_req;
    logic [3:0] fld_idx;
    logic [6:0] fld_pos;
    logic [9:0] csum_val;
    logic [1:0] csum_len;

    function automatic t_word verdict_of(t_status s);
        t_word r;
        r = '0;
        r.kind = RK_VERDICT;
        r.status = s;
        r.command = cmd_val;
        ph = PH_WAIT;
        return r;
    endfunction

    function automatic bit parse_byte(input logic [7:0] c, output t_word r);
        bit dig;
        int hit;
        dig = (c >= CH_ZERO) && (c <= CH_NINE);
        r = '0;
        case (ph)
            PH_WAIT: begin
                if (c == CH_START) begin
                    ph = PH_CMD_FIRST;
                    sum_acc = '0;
                    cmd_val = '0;
                    cmd_len = '0;
                    fields_req = '0;
                    fld_idx = '0;
                    fld_pos = '0;
                    csum_val = '0;
                    csum_len = '0;
                end
                return 1'b0;
            end
            PH_CMD_FIRST: begin
                if (!dig) begin
                    r = verdict_of(ST_CMD_START);
                    return 1'b1;
                end
                cmd_val = 8'(c - CH_ZERO);
                cmd_len = 4'd1;
                sum_acc = sum_acc + c;
                ph = PH_CMD_MORE;
                return 1'b0;
            end
            PH_CMD_MORE: begin
                if (dig) begin
                    if (cmd_len >= CMD_DIGITS_MAX) begin
                        r = verdict_of(ST_CMD_CHAR);
                        return 1'b1;
                    end
                    cmd_val = 8'(cmd_val * 10 + (c - CH_ZERO));
                    cmd_len = cmd_len + 4'd1;
                    sum_acc = sum_acc + c;
                    return 1'b0;
                end
                if (c != CH_SEP) begin
                    r = verdict_of(ST_CMD_CHAR);
                    return 1'b1;
                end
                sum_acc = sum_acc + c;
                hit = -1;
                for (int k = 3; k >= 0; k--)
                    if (code_tab[k] == cmd_val) hit = k;
                if (hit < 0) begin
                    r = verdict_of(ST_UNKNOWN);
                    return 1'b1;
                end
                fields_req = (count_tab[hit] > MAX_FIELDS) ? 4'(MAX_FIELDS) : count_tab[hit];
                fld_idx = '0;
                fld_pos = '0;
                if (fields_req == 0) ph = PH_SUM_FIRST;
                else ph = PH_ARGS;
                return 1'b0;
            end
            PH_ARGS: begin
                if (c == CH_START || c == CH_END || fld_pos >= FIELD_BYTES) begin
                    r = verdict_of(ST_ARG);
                    return 1'b1;
                end
                sum_acc = sum_acc + c;
                if (c == CH_SEP) begin
                    fld_idx = fld_idx + 4'd1;
                    fld_pos = '0;
                    if (fld_idx >= fields_req) ph = PH_SUM_FIRST;
                    return 1'b0;
                end
                r.kind = RK_BYTE;
                r.index = fld_idx[2:0];
                r.pos = fld_pos[5:0];
                r.data = c;
                fld_pos = fld_pos + 7'd1;
                return 1'b1;
            end
            PH_SUM_FIRST: begin
                if (!dig) begin
                    r = verdict_of(ST_SUM_START);
                    return 1'b1;
                end
                csum_val = 10'(c - CH_ZERO);
                csum_len = 2'd1;
                ph = PH_SUM_MORE;
                return 1'b0;
            end
            PH_SUM_MORE: begin
                if (c == CH_END) begin
                    if (csum_val[7:0] == sum_acc) r = verdict_of(ST_OK);
                    else r = verdict_of(ST_MISMATCH);
                    return 1'b1;
                end
                if (dig && csum_len < SUM_DIGITS_MAX) begin
                    csum_val = 10'(csum_val * 10 + (c - CH_ZERO));
                    csum_len = csum_len + 2'd1;
                    return 1'b0;
                end
                r = verdict_of(ST_SUM_CHAR);
                return 1'b1;
            end
            default: begin
                ph = PH_WAIT;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic bit take_break();
        return !(cyc >= CALM_FROM && cyc < CALM_TO) && ($urandom_range(0, 99) < 13);
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // sender
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (rx_stream.size() != 0 && !take_break()) begin
                i_rx_byte <= rx_stream.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && bytes_taken >= HOLD_AT) begin
            i_out_stall <= 1'b1;
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else begin
            i_out_stall <= take_break();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_word got;
        t_word want;
        t_word pred;
        cyc++;
        if (cyc > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got.kind = o_result_kind;
                got.index = o_field_index;
                got.pos = o_field_pos;
                got.data = o_field_byte;
                got.status = t_status'(o_status);
                got.command = o_command;
                if (pending_results.size() == 0) begin
                    $error("output word with nothing expected");
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("result_kind", want.kind, got.kind);
                    check_field("field_index", want.index, got.index);
                    check_field("field_pos", want.pos, got.pos);
                    check_field("field_byte", want.data, got.data);
                    check_field("status", want.status, got.status);
                    check_field("command", want.command, got.command);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index < REG_ARG_COUNT_A) code_tab[i_cfg_index[1:0]] = i_cfg_data;
                else count_tab[i_cfg_index[1:0]] = i_cfg_data[3:0];
            end
            in_taken = i_in_valid && !o_in_stall;
            if (in_taken) begin
                bytes_taken++;
                if (parse_byte(i_rx_byte, pred)) pending_results.push_back(pred);
            end
        end
    end

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) rx_stream.push_back(s[i]);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic load_table(input logic [7:0] ca, cb, cc, cd, input logic [3:0] na, nb, nc, nd);
        write_reg(REG_CMD_CODE_A, ca);
        write_reg(REG_CMD_CODE_B, cb);
        write_reg(REG_CMD_CODE_C, cc);
        write_reg(REG_CMD_CODE_D, cd);
        write_reg(REG_ARG_COUNT_A, {4'h0, na});
        write_reg(REG_ARG_COUNT_B, {4'h0, nb});
        write_reg(REG_ARG_COUNT_C, {4'h0, nc});
        write_reg(REG_ARG_COUNT_D, {4'h0, nd});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (rx_stream.size() != 0 || i_in_valid || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic gen_frame();
        logic [7:0] fb[$];
        logic [7:0] csum;
        logic [7:0] c;
        int cval, nf, flen, sv, roll, p;
        string s;
        if ($urandom_range(0, 99) < 15)
            repeat ($urandom_range(1, 3)) rx_stream.push_back(8'($urandom_range(0, 255)));
        fb.push_back(CH_START);
        if ($urandom_range(0, 99) < 85) cval = code_tab[$urandom_range(0, 3)];
        else cval = $urandom_range(0, 999);
        roll = $urandom_range(0, 99);
        if (roll < 3) s = $sformatf("%0d%09d", $urandom_range(1, 9), $urandom_range(0, 999999999));
        else if (roll < 10) s = $sformatf("%09d", cval);
        else s = $sformatf("%0d", cval);
        for (int i = 0; i < s.len(); i++) fb.push_back(s[i]);
        fb.push_back(CH_SEP);
        nf = $urandom_range(0, 2);
        for (int k = 3; k >= 0; k--)
            if (code_tab[k] == cval[7:0])
                nf = (count_tab[k] > MAX_FIELDS) ? MAX_FIELDS : count_tab[k];
        for (int f = 0; f < nf; f++) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) flen = FIELD_BYTES;
            else if (roll < 8) flen = FIELD_BYTES + 1;
            else flen = $urandom_range(0, 4);
            repeat (flen) begin
                do c = 8'($urandom_range(0, 255));
                while (c == CH_START || c == CH_END || c == CH_SEP);
                fb.push_back(c);
            end
            fb.push_back(CH_SEP);
        end
        csum = '0;
        for (int i = 1; i < fb.size(); i++) csum = csum + fb[i];
        sv = csum;
        roll = $urandom_range(0, 9);
        if (roll == 0) sv = (csum + $urandom_range(1, 255)) % 256;
        else if (roll == 1 && csum + 512 <= 999) sv = csum + 512;
        else if (roll == 2) sv = csum + 256;
        if (roll == 3) s = $sformatf("%03d", sv);
        else if (roll == 4) s = $sformatf("%03d%0d", sv, $urandom_range(0, 9));
        else s = $sformatf("%0d", sv);
        for (int i = 0; i < s.len(); i++) fb.push_back(s[i]);
        fb.push_back(CH_END);
        // broken frames
        if ($urandom_range(0, 99) < 10) begin
            p = $urandom_range(1, fb.size() - 1);
            c = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 2))
                0: fb[p] = c;
                1: fb.insert(p, c);
                default: fb.delete(p);
            endcase
        end
        foreach (fb[i]) rx_stream.push_back(fb[i]);
        frame_bytes += fb.size();
    endtask

    task automatic random_frames(input int n);
        int stop_at;
        stop_at = frame_bytes + n;
        while (frame_bytes < stop_at) gen_frame();
    endtask

    initial begin
        code_tab = '{8'd1, 8'd2, 8'd3, 8'd4};
        count_tab = '{4'd2, 4'd5, 4'd0, 4'd3};
        ph = PH_WAIT;
        sum_acc = '0;
        cmd_val = '0;
        cmd_len = '0;
        fields_req = '0;
        fld_idx = '0;
        fld_pos = '0;
        csum_val = '0;
        csum_len = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames on the default table
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'hFF);
        push_str("<3|175>");
        push_str("<x<12a");
        push_str("<1<>");
        push_str("<9|");
        push_str("<1|a|<");
        push_str("<3|1234");
        push_str("<3|>");
        push_str("<3|9>");
        random_frames(PHASE_LEN - 60);
        drain();

        // extreme codes, zero, max and oversized field counts
        load_table(8'd0, 8'd255, 8'h80, 8'h5A, 4'd0, 4'd8, 4'd15, 4'd1);
        random_frames(PHASE_LEN);
        drain();

        // duplicate codes: first entry wins
        load_table(8'd7, 8'd7, 8'd200, 8'd7, 4'd3, 4'd9, 4'd2, 4'd6);
        push_str("<7|a|b|c|");
        random_frames(PHASE_LEN);
        drain();

        load_table(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        random_frames(PHASE_LEN);
        drain();

        if (mismatches == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule
